FILE: design/pcs_pkg.sv
// shared types and constants for the primitive count statistics block
// topology codes, queue entry layout and state machine types; no dependencies
`default_nettype none

package pcs_pkg;

   localparam int TOPO_W  = 6;
   localparam int VERT_W  = 32;
   localparam int INST_W  = 32;
   localparam int CNT_W   = 64;
   localparam int REQ_W   = 72;
   localparam int RSP_W   = 5 * CNT_W;

   localparam logic [TOPO_W-1:0] TOPO_POINT_LIST     = 6'd0;
   localparam logic [TOPO_W-1:0] TOPO_LINE_LIST      = 6'd1;
   localparam logic [TOPO_W-1:0] TOPO_LINE_STRIP     = 6'd2;
   localparam logic [TOPO_W-1:0] TOPO_LINE_LOOP      = 6'd3;
   localparam logic [TOPO_W-1:0] TOPO_LINE_LIST_ADJ  = 6'd4;
   localparam logic [TOPO_W-1:0] TOPO_LINE_STRIP_ADJ = 6'd5;
   localparam logic [TOPO_W-1:0] TOPO_TRI_LIST       = 6'd6;
   localparam logic [TOPO_W-1:0] TOPO_TRI_STRIP      = 6'd7;
   localparam logic [TOPO_W-1:0] TOPO_TRI_FAN        = 6'd8;
   localparam logic [TOPO_W-1:0] TOPO_TRI_LIST_ADJ   = 6'd9;
   localparam logic [TOPO_W-1:0] TOPO_TRI_STRIP_ADJ  = 6'd10;
   localparam int                TOPO_PATCH_FIRST    = 11;

   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // divider retires this many quotient bits per cycle
   localparam int DIV_STEP   = 4;
   localparam int DIV_CYCLES = VERT_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_POINT,
      KIND_LINE,
      KIND_TRI,
      KIND_PATCH,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [VERT_W-1:0]   prims;
      logic [INST_W-1:0]   inst;
   } entry_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_ACC
   } back_state_type;

endpackage

`default_nettype wire

FILE: design/pcs_front.sv
// front end: accepts draw transactions, classifies the topology and works out
// primitives per instance, radix-16 divider for line and triangle lists and patches; uses pcs_pkg
`default_nettype none

module pcs_front #(
   parameter int MAX_PATCH_POINTS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_cmd,
   input  wire logic [pcs_pkg::TOPO_W-1:0]  req_topology,
   input  wire logic [pcs_pkg::VERT_W-1:0]  req_vertex_count,
   input  wire logic [pcs_pkg::INST_W-1:0]  req_instance_count,
   output logic                             q_push,
   output pcs_pkg::entry_type               q_entry,
   input  wire logic                        q_full
);

   localparam int DIV_W = ($clog2(MAX_PATCH_POINTS + 1) < 2) ? 2 :
                          $clog2(MAX_PATCH_POINTS + 1);

   pcs_pkg::front_state_type        state_ff, state_in;
   pcs_pkg::kind_type               kind_ff, kind_in;
   logic [pcs_pkg::VERT_W-1:0]      prims_ff, prims_in;
   logic [pcs_pkg::INST_W-1:0]      inst_ff, inst_in;
   logic [DIV_W-1:0]                divisor_ff, divisor_in;
   logic [DIV_W-1:0]                rem_ff, rem_in;
   logic [pcs_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   // classification of the incoming transaction
   pcs_pkg::kind_type               cls_kind;
   logic [pcs_pkg::VERT_W-1:0]      cls_prims;
   logic                            cls_div;
   logic [DIV_W-1:0]                cls_divisor;

   // one divider step
   logic [pcs_pkg::VERT_W-1:0]      step_quo;
   logic [DIV_W-1:0]                step_rem;

   always_comb begin
      logic [pcs_pkg::VERT_W-1:0] n;
      n           = req_vertex_count;
      cls_kind    = pcs_pkg::KIND_NONE;
      cls_prims   = '0;
      cls_div     = 1'b0;
      cls_divisor = DIV_W'(2);
      unique case (req_topology) inside
         pcs_pkg::TOPO_POINT_LIST: begin
            cls_kind  = pcs_pkg::KIND_POINT;
            cls_prims = n;
         end
         pcs_pkg::TOPO_LINE_LIST, pcs_pkg::TOPO_LINE_LIST_ADJ: begin
            cls_kind    = pcs_pkg::KIND_LINE;
            cls_prims   = n;
            cls_div     = 1'b1;
            cls_divisor = DIV_W'(2);
         end
         pcs_pkg::TOPO_LINE_STRIP, pcs_pkg::TOPO_LINE_STRIP_ADJ: begin
            cls_kind  = pcs_pkg::KIND_LINE;
            cls_prims = (n >= 32'd2) ? n - 32'd1 : '0;
         end
         pcs_pkg::TOPO_LINE_LOOP: begin
            cls_kind = pcs_pkg::KIND_LINE;
            if (n == 32'd2) begin
               cls_prims = 32'd1;
            end else if (n >= 32'd3) begin
               cls_prims = n;
            end
         end
         pcs_pkg::TOPO_TRI_LIST, pcs_pkg::TOPO_TRI_LIST_ADJ: begin
            cls_kind    = pcs_pkg::KIND_TRI;
            cls_prims   = n;
            cls_div     = 1'b1;
            cls_divisor = DIV_W'(3);
         end
         pcs_pkg::TOPO_TRI_STRIP, pcs_pkg::TOPO_TRI_FAN, pcs_pkg::TOPO_TRI_STRIP_ADJ: begin
            cls_kind  = pcs_pkg::KIND_TRI;
            cls_prims = (n >= 32'd3) ? n - 32'd2 : '0;
         end
         default: begin
            if (int'(req_topology) >= pcs_pkg::TOPO_PATCH_FIRST &&
                int'(req_topology) < pcs_pkg::TOPO_PATCH_FIRST + MAX_PATCH_POINTS) begin
               cls_kind    = pcs_pkg::KIND_PATCH;
               cls_prims   = n;
               cls_div     = 1'b1;
               cls_divisor = DIV_W'(int'(req_topology) - (pcs_pkg::TOPO_PATCH_FIRST - 1));
            end
         end
      endcase
      if (req_cmd == pcs_pkg::CMD_CLEAR) begin
         cls_kind  = pcs_pkg::KIND_CLEAR;
         cls_prims = '0;
         cls_div   = 1'b0;
      end
   end

   // restoring division, dividend shifts out at the top while quotient bits shift in
   always_comb begin
      logic [DIV_W:0] trial;
      step_quo = prims_ff;
      step_rem = rem_ff;
      for (int i = 0; i < pcs_pkg::DIV_STEP; i++) begin
         trial    = {step_rem, step_quo[pcs_pkg::VERT_W-1]};
         step_quo = {step_quo[pcs_pkg::VERT_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            step_rem    = DIV_W'(trial - {1'b0, divisor_ff});
            step_quo[0] = 1'b1;
         end else begin
            step_rem = trial[DIV_W-1:0];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      prims_in   = prims_ff;
      inst_in    = inst_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      req_ready  = 1'b0;
      q_push     = 1'b0;
      unique case (state_ff)
         pcs_pkg::F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = cls_kind;
               prims_in   = cls_prims;
               inst_in    = req_instance_count;
               divisor_in = cls_divisor;
               rem_in     = '0;
               cnt_in     = '0;
               state_in   = cls_div ? pcs_pkg::F_DIV : pcs_pkg::F_PUSH;
            end
         end
         pcs_pkg::F_DIV: begin
            prims_in = step_quo;
            rem_in   = step_rem;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == pcs_pkg::DIV_CNT_W'(pcs_pkg::DIV_CYCLES - 1)) begin
               state_in = pcs_pkg::F_PUSH;
            end
         end
         pcs_pkg::F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = pcs_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = pcs_pkg::F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcs_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      prims_ff   <= prims_in;
      inst_ff    <= inst_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
   end

   assign q_entry.kind  = kind_ff;
   assign q_entry.prims = prims_ff;
   assign q_entry.inst  = inst_ff;

endmodule

`default_nettype wire

FILE: design/pcs_queue.sv
// two-entry queue between the front end and the counter back end
// carries pcs_pkg::entry_type; uses pcs_pkg
`default_nettype none

module pcs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire pcs_pkg::entry_type  push_entry,
   output logic                     full,
   input  wire logic                pop,
   output pcs_pkg::entry_type       pop_entry,
   output logic                     empty
);

   pcs_pkg::entry_type              mem_ff [pcs_pkg::QUEUE_DEPTH];
   logic [pcs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pcs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pcs_pkg::QPTR_W:0]        count_ff, count_in;

   localparam logic [pcs_pkg::QPTR_W-1:0] LAST_PTR = pcs_pkg::QPTR_W'(pcs_pkg::QUEUE_DEPTH - 1);
   localparam logic [pcs_pkg::QPTR_W:0]   FULL_CNT = (pcs_pkg::QPTR_W + 1)'(pcs_pkg::QUEUE_DEPTH);

   assign full      = count_ff == FULL_CNT;
   assign empty     = count_ff == '0;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: design/pcs_back.sv
// back end: multiplies primitives by instances and updates the five counters,
// which also serve as the result register; uses pcs_pkg
`default_nettype none

module pcs_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_empty,
   output logic                             q_pop,
   input  wire pcs_pkg::entry_type          q_entry,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [pcs_pkg::CNT_W-1:0]        draw_total,
   output logic [pcs_pkg::CNT_W-1:0]        point_total,
   output logic [pcs_pkg::CNT_W-1:0]        line_total,
   output logic [pcs_pkg::CNT_W-1:0]        triangle_total,
   output logic [pcs_pkg::CNT_W-1:0]        patch_total
);

   pcs_pkg::back_state_type         state_ff, state_in;
   pcs_pkg::kind_type               kind_ff, kind_in;
   logic [pcs_pkg::CNT_W-1:0]       prod_ff, prod_in;
   logic                            valid_ff, valid_in;
   logic [pcs_pkg::CNT_W-1:0]       draw_ff, draw_in;
   logic [pcs_pkg::CNT_W-1:0]       point_ff, point_in;
   logic [pcs_pkg::CNT_W-1:0]       line_ff, line_in;
   logic [pcs_pkg::CNT_W-1:0]       tri_ff, tri_in;
   logic [pcs_pkg::CNT_W-1:0]       patch_ff, patch_in;
   logic                            load;

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      prod_in  = prod_ff;
      valid_in = valid_ff;
      draw_in  = draw_ff;
      point_in = point_ff;
      line_in  = line_ff;
      tri_in   = tri_ff;
      patch_in = patch_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      if (rsp_valid && rsp_ready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         pcs_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               kind_in  = q_entry.kind;
               prod_in  = pcs_pkg::CNT_W'(q_entry.prims) * pcs_pkg::CNT_W'(q_entry.inst);
               state_in = pcs_pkg::B_ACC;
            end
         end
         pcs_pkg::B_ACC: begin
            // counters double as the result, so wait until the last one is taken
            if (!valid_ff || rsp_ready) begin
               load     = 1'b1;
               valid_in = 1'b1;
               state_in = pcs_pkg::B_IDLE;
               draw_in  = draw_ff + 1'b1;
               case (kind_ff)
                  pcs_pkg::KIND_POINT: point_in = point_ff + prod_ff;
                  pcs_pkg::KIND_LINE:  line_in  = line_ff + prod_ff;
                  pcs_pkg::KIND_TRI:   tri_in   = tri_ff + prod_ff;
                  pcs_pkg::KIND_PATCH: patch_in = patch_ff + prod_ff;
                  pcs_pkg::KIND_CLEAR: begin
                     draw_in  = '0;
                     point_in = '0;
                     line_in  = '0;
                     tri_in   = '0;
                     patch_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         default: begin
            state_in = pcs_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcs_pkg::B_IDLE;
         valid_ff <= 1'b0;
         draw_ff  <= '0;
         point_ff <= '0;
         line_ff  <= '0;
         tri_ff   <= '0;
         patch_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         draw_ff  <= draw_in;
         point_ff <= point_in;
         line_ff  <= line_in;
         tri_ff   <= tri_in;
         patch_ff <= patch_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      prod_ff <= prod_in;
   end

   assign rsp_valid      = valid_ff;
   assign draw_total     = draw_ff;
   assign point_total    = point_ff;
   assign line_total     = line_ff;
   assign triangle_total = tri_ff;
   assign patch_total    = patch_ff;

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      load && kind_ff == pcs_pkg::KIND_CLEAR |=>
         draw_ff == '0 && point_ff == '0 && line_ff == '0 && tri_ff == '0 && patch_ff == '0)
      else $error("clear left a counter nonzero");

   a_draw_step: assert property (@(posedge clock) disable iff (reset)
      load && kind_ff != pcs_pkg::KIND_CLEAR |=> draw_ff == $past(draw_ff) + 1'b1)
      else $error("draw counter did not advance by one");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == pcs_pkg::B_IDLE)
      else $error("queue popped while a draw is still being applied");

endmodule

`default_nettype wire

FILE: design/primitive_count_statistics.sv
// the front end accepts a transaction, runs line, triangle and patch lists through
// a radix-16 divider and pushes it into the queue; the back end pops it and adds it
// to the counters, which are the registered result; the front end takes a new
// transaction only once it has pushed the last one into the queue
// reset: synchronous, clears all five counters, the queue and both state machines
`default_nettype none

module primitive_count_statistics #(
   parameter int MAX_PATCH_POINTS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // topology [5:0], vertex_count [37:6], instance_count [69:38], zero [71:70]
   input  wire logic [pcs_pkg::REQ_W-1:0]   req_tdata,
   // cmd [0]
   input  wire logic [0:0]                  req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // draw_total [63:0], point_total [127:64], line_total [191:128],
   // triangle_total [255:192], patch_total [319:256]
   output logic [pcs_pkg::RSP_W-1:0]        rsp_tdata
);

   logic                  q_push;
   logic                  q_pop;
   logic                  q_full;
   logic                  q_empty;
   pcs_pkg::entry_type    push_entry;
   pcs_pkg::entry_type    pop_entry;

   pcs_front #(
      .MAX_PATCH_POINTS (MAX_PATCH_POINTS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_tvalid),
      .req_ready          (req_tready),
      .req_cmd            (req_tuser[0]),
      .req_topology       (req_tdata[5:0]),
      .req_vertex_count   (req_tdata[37:6]),
      .req_instance_count (req_tdata[69:38]),
      .q_push             (q_push),
      .q_entry            (push_entry),
      .q_full             (q_full)
   );

   pcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   pcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_entry        (pop_entry),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .draw_total     (rsp_tdata[63:0]),
      .point_total    (rsp_tdata[127:64]),
      .line_total     (rsp_tdata[191:128]),
      .triangle_total (rsp_tdata[255:192]),
      .patch_total    (rsp_tdata[319:256])
   );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for primitive_count_statistics: clocked driver and monitor,
// an in-bench model of the five draw statistics counters, in-order result scoreboard
// depends on pcs_pkg and the primitive_count_statistics rtl

module tb;
   import pcs_pkg::*;

   localparam int MAX_PATCH        = 32;
   localparam int TOPO_PATCH_LAST  = TOPO_PATCH_FIRST + MAX_PATCH - 1;
   localparam int RANDOM_DRAWS     = 650;
   localparam int HOLD_CYCLES      = 300;
   localparam int IDLE_LIMIT       = 4000;
   localparam int DRAIN_CYCLES     = 40;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct {
      logic               cmd;
      logic [TOPO_W-1:0]  topology;
      logic [VERT_W-1:0]  vertex_count;
      logic [INST_W-1:0]  instance_count;
   } draw_item_t;

   typedef struct {
      logic [CNT_W-1:0] draws;
      logic [CNT_W-1:0] points;
      logic [CNT_W-1:0] lines;
      logic [CNT_W-1:0] tris;
      logic [CNT_W-1:0] patches;
   } counter_set_t;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;   // topology, vertex_count, instance_count, zero pad
   logic [0:0]       req_tuser  = '0;   // cmd
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // draw, point, line, triangle, patch totals

   draw_item_t   draw_queue[$];
   counter_set_t totals_due[$];
   counter_set_t tally;

   draw_item_t   cur_draw;
   bit           offering;
   int unsigned  req_gap;
   int unsigned  draws_sent;
   int unsigned  rsp_gap;
   int unsigned  rsp_seen;
   int unsigned  hold_left;
   int unsigned  holds_done;
   int unsigned  idle_cycles;
   int unsigned  errors;

   primitive_count_statistics #(.MAX_PATCH_POINTS(MAX_PATCH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // running totals after one command; products always fit in 64 bits
   function automatic void apply_command(input draw_item_t d);
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] inst;
      logic [CNT_W-1:0] per_inst;
      n    = CNT_W'(d.vertex_count);
      inst = CNT_W'(d.instance_count);
      if (d.cmd == CMD_CLEAR) begin
         tally = '{default: '0};
      end else begin
         tally.draws += 1;
         case (d.topology)
            TOPO_POINT_LIST: begin
               tally.points += n * inst;
            end
            TOPO_LINE_LIST, TOPO_LINE_LIST_ADJ: begin
               tally.lines += (n / 2) * inst;
            end
            TOPO_LINE_STRIP, TOPO_LINE_STRIP_ADJ: begin
               per_inst = (n >= 2) ? n - 1 : '0;
               tally.lines += per_inst * inst;
            end
            TOPO_LINE_LOOP: begin
               // a loop of two vertices closes onto the same edge
               per_inst = (n == 2) ? CNT_W'(1) : (n >= 3) ? n : '0;
               tally.lines += per_inst * inst;
            end
            TOPO_TRI_LIST, TOPO_TRI_LIST_ADJ: begin
               tally.tris += (n / 3) * inst;
            end
            TOPO_TRI_STRIP, TOPO_TRI_FAN, TOPO_TRI_STRIP_ADJ: begin
               per_inst = (n >= 3) ? n - 2 : '0;
               tally.tris += per_inst * inst;
            end
            default: begin
               if (d.topology >= TOPO_PATCH_FIRST && d.topology <= TOPO_PATCH_LAST)
                  tally.patches += (n / (d.topology - TOPO_PATCH_FIRST + 1)) * inst;
            end
         endcase
      end
      totals_due.push_back(tally);
   endfunction

   function automatic void check_field(input string label, input logic [CNT_W-1:0] want,
                                       input logic [CNT_W-1:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("mismatch on %s: expected %h, got %h", label, want, got);
      end
   endfunction

   function automatic void add_draw(input logic cmd, input logic [TOPO_W-1:0] topo,
                                    input logic [31:0] n, input logic [31:0] inst);
      draw_item_t d;
      d.cmd            = cmd;
      d.topology       = topo;
      d.vertex_count   = n;
      d.instance_count = inst;
      draw_queue.push_back(d);
   endfunction

   function automatic draw_item_t random_draw();
      draw_item_t  d;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      d.cmd = (pick < 4) ? CMD_CLEAR : CMD_RECORD;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         d.topology = TOPO_W'($urandom_range(0, TOPO_TRI_STRIP_ADJ));
      else if (pick < 88)
         d.topology = TOPO_W'($urandom_range(TOPO_PATCH_FIRST, TOPO_PATCH_LAST));
      else
         d.topology = TOPO_W'($urandom_range(TOPO_PATCH_LAST + 1, 63));
      pick = $urandom_range(0, 99);
      if (pick < 40)
         d.vertex_count = $urandom_range(0, 12);
      else if (pick < 65)
         d.vertex_count = $urandom_range(0, 65535);
      else if (pick < 90)
         d.vertex_count = $urandom;
      else
         d.vertex_count = ($urandom_range(0, 1) != 0) ? ALL_ONES : $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 30)
         d.instance_count = 1;
      else if (pick < 40)
         d.instance_count = 0;
      else if (pick < 70)
         d.instance_count = $urandom_range(0, 8);
      else
         d.instance_count = $urandom;
      return d;
   endfunction

   // driver: one transaction offered at a time, random gap drawn after each accept
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         offering   = 1'b0;
         req_gap    = 0;
         draws_sent = 0;
      end else begin
         if (offering && req_tready) begin
            apply_command(cur_draw);
            offering = 1'b0;
            draws_sent++;
            // every third stretch of 40 transactions runs back to back
            req_gap = ((draws_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 15);
         end
         if (!offering) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (draw_queue.size() != 0) begin
               cur_draw = draw_queue.pop_front();
               offering = 1'b1;
               req_tdata <= {2'b00, cur_draw.instance_count, cur_draw.vertex_count,
                             cur_draw.topology};
               req_tuser <= cur_draw.cmd;
            end
         end
         req_tvalid <= offering;
      end
   end

   // monitor: compares each result with the oldest predicted totals
   always @(posedge clock) begin
      counter_set_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_seen   <= 0;
         rsp_gap    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen <= rsp_seen + 1;
            if (totals_due.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("result with nothing expected: %h", rsp_tdata);
            end else begin
               want = totals_due.pop_front();
               check_field("draw_total",     want.draws,   rsp_tdata[0*CNT_W +: CNT_W]);
               check_field("point_total",    want.points,  rsp_tdata[1*CNT_W +: CNT_W]);
               check_field("line_total",     want.lines,   rsp_tdata[2*CNT_W +: CNT_W]);
               check_field("triangle_total", want.tris,    rsp_tdata[3*CNT_W +: CNT_W]);
               check_field("patch_total",    want.patches, rsp_tdata[4*CNT_W +: CNT_W]);
            end
            rsp_gap = ((rsp_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 15);
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver hold-off, twice, so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && rsp_seen >= 60) ||
                   (holds_done == 1 && rsp_seen >= 400)) begin
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      tally  = '{default: '0};
      errors = 0;

      // directed: extremes, every topology, wrap, clear, unknown codes
      add_draw(CMD_RECORD, TOPO_POINT_LIST,     ALL_ONES, ALL_ONES);
      add_draw(CMD_RECORD, TOPO_POINT_LIST,     ALL_ONES, ALL_ONES);  // point total wraps
      add_draw(CMD_RECORD, TOPO_POINT_LIST,     0,        7);
      add_draw(CMD_RECORD, TOPO_LINE_LIST,      7,        3);
      add_draw(CMD_RECORD, TOPO_LINE_STRIP,     1,        5);
      add_draw(CMD_RECORD, TOPO_LINE_STRIP,     2,        1);
      add_draw(CMD_RECORD, TOPO_LINE_LOOP,      1,        4);
      add_draw(CMD_RECORD, TOPO_LINE_LOOP,      2,        9);
      add_draw(CMD_RECORD, TOPO_LINE_LOOP,      3,        2);
      add_draw(CMD_RECORD, TOPO_LINE_LIST_ADJ,  ALL_ONES, 1);
      add_draw(CMD_RECORD, TOPO_LINE_STRIP_ADJ, 5,        2);
      add_draw(CMD_RECORD, TOPO_TRI_LIST,       8,        1);
      add_draw(CMD_RECORD, TOPO_TRI_STRIP,      2,        6);
      add_draw(CMD_RECORD, TOPO_TRI_STRIP,      3,        1);
      add_draw(CMD_RECORD, TOPO_TRI_FAN,        10,       3);
      add_draw(CMD_RECORD, TOPO_TRI_LIST_ADJ,   9,        0);  // no instances
      add_draw(CMD_RECORD, TOPO_TRI_STRIP_ADJ,  ALL_ONES, ALL_ONES);
      add_draw(CMD_RECORD, TOPO_W'(TOPO_PATCH_FIRST),     ALL_ONES, 2);
      add_draw(CMD_RECORD, TOPO_W'(TOPO_PATCH_FIRST + 2), 7,        1);
      add_draw(CMD_RECORD, TOPO_W'(TOPO_PATCH_LAST),      100,      5);
      add_draw(CMD_RECORD, TOPO_W'(TOPO_PATCH_LAST),      31,       ALL_ONES);
      add_draw(CMD_RECORD, TOPO_W'(TOPO_PATCH_LAST + 1),  50,       3);  // unknown code
      add_draw(CMD_RECORD, '1,                  ALL_ONES, ALL_ONES);
      add_draw(CMD_CLEAR,  '1,                  ALL_ONES, ALL_ONES);
      add_draw(CMD_RECORD, TOPO_LINE_LIST,      4,        1);

      repeat (RANDOM_DRAWS) draw_queue.push_back(random_draw());

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (draw_queue.size() != 0 || offering || totals_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
